### src/clxm_pkg.sv
// constants, types and mixing functions for the combined lcg/xorshift/mwc generator
`default_nettype none

package clxm_pkg;

	localparam logic [63:0] V_INIT   = 64'd4101842887655102017;
	localparam logic [63:0] LCG_MUL  = 64'd2862933555777941757;
	localparam logic [63:0] LCG_ADD  = 64'd7046029254386353087;
	localparam logic [31:0] MWC_MUL  = 32'd4294957665;

	localparam logic [1:0] WIDTH_64 = 2'd0;
	localparam logic [1:0] WIDTH_32 = 2'd1;
	localparam logic [1:0] WIDTH_16 = 2'd2;
	localparam logic [1:0] WIDTH_8  = 2'd3;

	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_SKIP = 1'b1;

	localparam logic [1:0] CFG_SEED  = 2'd0;
	localparam logic [1:0] CFG_WIDTH = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_NEXT    = 4'b0010,
		S_STEP    = 4'b0100,
		S_DELIVER = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		PH_LO_LO = 2'd0,
		PH_HI_LO = 2'd1,
		PH_LO_HI = 2'd2,
		PH_MWC   = 2'd3
	} phase_t;

	function automatic logic [63:0] xorshift_step(input logic [63:0] x);
		logic [63:0] t;
		t = x ^ (x >> 17);
		t = t ^ (t << 31);
		t = t ^ (t >> 8);
		return t;
	endfunction

	function automatic logic [63:0] mix_value(input logic [63:0] l, input logic [63:0] x,
		input logic [63:0] m);
		logic [63:0] t;
		t = l ^ (l << 21);
		t = t ^ (t >> 35);
		t = t ^ (t << 4);
		return (t + x) ^ m;
	endfunction

endpackage

`default_nettype wire

### src/combined_lcg_xorshift_mwc_prng_core.sv
// combined lcg/xorshift/mwc random generator with buffered narrow draws and skips
//
// One 32x32 multiplier is shared by a small sequencer: a generator step forms the three partial
// products of the 64-bit lcg multiply and then the mwc product, one per phase, after a dispatch
// state. A 64-bit draw runs one generator step before its result; a narrow draw is served from
// the bit buffer, or first refills the buffer with one step. A skip of n values needs n
// generator steps at 64 bits; at narrow widths it first uses the values left in the buffer and
// steps a word at a time for the rest. After reset and after every seed write the block runs
// three steps of seeding before it takes an item. The next item is accepted while a result
// waits in the output register. Configuration is taken only while the block is idle.
`default_nettype none

module combined_lcg_xorshift_mwc_prng_core #(
	parameter int SKIP_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // skip_count
	input  wire logic        s_axis_tuser,  // kind
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [63:0] m_axis_tdata,  // random_value
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);
	import clxm_pkg::*;

	localparam int CNT_W = SKIP_COUNT_BITS;
	localparam int EXT_W = CNT_W + 16;

	state_t              state_q;
	phase_t              phase_q;
	logic [63:0]         acc_q;
	logic [63:0]         lcg_q;
	logic [63:0]         xs_q;
	logic [63:0]         mwc_q;
	logic [63:0]         buf_q;
	logic [6:0]          bits_q;
	logic [1:0]          width_q;
	logic [CNT_W-1:0]    steps_q;
	logic [3:0]          rem_q;
	logic                val_step_q;
	logic                cur_val_q;
	logic                draw_q;
	logic                seed_q;
	logic [1:0]          seed_phase_q;
	logic                out_valid_q;
	logic [63:0]         out_data_q;

	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic [63:0]         mul_p;
	logic [63:0]         lcg_new;
	logic [63:0]         xs_new;
	logic [63:0]         mwc_new;
	logic [63:0]         gen;
	logic                wide;
	logic [6:0]          w_amt;
	logic [2:0]          lw;
	logic [6:0]          avail;
	logic [63:0]         mask;
	logic [EXT_W-1:0]    ext_cnt;
	logic [EXT_W-1:0]    ext_avail;
	logic [EXT_W-1:0]    diff;
	logic [EXT_W-1:0]    diff_steps;
	logic [CNT_W-1:0]    cnt_in;
	logic                cnt_gt;
	logic [2:0]          per_mask;
	logic [9:0]          sh;

	always_comb begin
		case (phase_q)
			PH_LO_LO: begin
				mul_a = lcg_q[31:0];
				mul_b = LCG_MUL[31:0];
			end
			PH_HI_LO: begin
				mul_a = lcg_q[63:32];
				mul_b = LCG_MUL[31:0];
			end
			PH_LO_HI: begin
				mul_a = lcg_q[31:0];
				mul_b = LCG_MUL[63:32];
			end
			default: begin
				mul_a = mwc_q[31:0];
				mul_b = MWC_MUL;
			end
		endcase
	end

	assign mul_p   = {32'b0, mul_a} * {32'b0, mul_b};
	assign lcg_new = acc_q + LCG_ADD;
	assign xs_new  = xorshift_step(xs_q);
	assign mwc_new = mul_p + {32'b0, mwc_q[63:32]};
	assign gen     = mix_value(lcg_q, xs_q, mwc_q);

	assign wide     = (width_q == WIDTH_64);
	assign w_amt    = 7'd64 >> width_q;
	assign lw       = 3'd6 - {1'b0, width_q};
	assign avail    = bits_q >> lw;
	assign mask     = {64{1'b1}} >> (7'd64 - w_amt);
	assign per_mask = 3'b111 >> (2'd3 - width_q);

	assign ext_cnt    = {{16{1'b0}}, CNT_W'(s_axis_tdata)};
	assign cnt_in     = ext_cnt[CNT_W-1:0];
	assign ext_avail  = EXT_W'(avail);
	assign cnt_gt     = ({{16{1'b0}}, cnt_in} > ext_avail);
	assign diff       = {{16{1'b0}}, cnt_in} - ext_avail;
	assign diff_steps = diff >> width_q;
	assign sh         = {6'b0, rem_q} << lw;

	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_NEXT;
			phase_q      <= PH_LO_LO;
			acc_q        <= '0;
			lcg_q        <= V_INIT;
			xs_q         <= V_INIT;
			mwc_q        <= 64'd1;
			buf_q        <= '0;
			bits_q       <= '0;
			width_q      <= WIDTH_64;
			steps_q      <= '0;
			rem_q        <= '0;
			val_step_q   <= 1'b0;
			cur_val_q    <= 1'b0;
			draw_q       <= 1'b0;
			seed_q       <= 1'b1;
			seed_phase_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_axis_tready && state_q != S_DELIVER) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) begin
						unique case (cfg_index)
							CFG_SEED: begin
								lcg_q        <= cfg_data ^ V_INIT;
								xs_q         <= V_INIT;
								mwc_q        <= 64'd1;
								buf_q        <= '0;
								bits_q       <= '0;
								seed_q       <= 1'b1;
								seed_phase_q <= '0;
								state_q      <= S_NEXT;
							end
							CFG_WIDTH: begin
								width_q <= cfg_data[1:0];
								buf_q   <= '0;
								bits_q  <= '0;
							end
							default: ;
						endcase
					end else if (s_axis_tvalid) begin
						state_q   <= S_NEXT;
						cur_val_q <= 1'b0;
						if (s_axis_tuser == KIND_DRAW) begin
							draw_q     <= 1'b1;
							steps_q    <= '0;
							rem_q      <= '0;
							val_step_q <= wide || (bits_q < w_amt);
						end else if (wide) begin
							draw_q     <= 1'b0;
							steps_q    <= cnt_in;
							rem_q      <= '0;
							val_step_q <= 1'b0;
						end else if (cnt_gt) begin
							draw_q     <= 1'b0;
							steps_q    <= diff_steps[CNT_W-1:0];
							rem_q      <= {1'b0, diff[2:0] & per_mask};
							val_step_q <= 1'b1;
						end else begin
							draw_q     <= 1'b0;
							steps_q    <= '0;
							rem_q      <= ext_cnt[3:0];
							val_step_q <= 1'b0;
						end
					end
				end
				S_NEXT: begin
					if (seed_q) begin
						if (seed_phase_q == 2'd3) begin
							seed_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_STEP;
						end
					end else if (cur_val_q) begin
						cur_val_q <= 1'b0;
						if (wide) begin
							state_q <= S_DELIVER;
						end else begin
							buf_q  <= gen;
							bits_q <= 7'd64;
						end
					end else if (steps_q != '0) begin
						steps_q <= steps_q - CNT_W'(1);
						state_q <= S_STEP;
					end else if (val_step_q) begin
						val_step_q <= 1'b0;
						cur_val_q  <= 1'b1;
						state_q    <= S_STEP;
					end else if (draw_q) begin
						state_q <= S_DELIVER;
					end else begin
						if (rem_q != '0) begin
							if (sh >= 10'd64) begin
								buf_q  <= '0;
								bits_q <= '0;
							end else begin
								buf_q  <= buf_q >> sh[5:0];
								bits_q <= bits_q - sh[6:0];
							end
						end
						rem_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_STEP: begin
					case (phase_q)
						PH_LO_LO: begin
							acc_q   <= mul_p;
							phase_q <= PH_HI_LO;
						end
						PH_HI_LO: begin
							acc_q[63:32] <= acc_q[63:32] + mul_p[31:0];
							phase_q      <= PH_LO_HI;
						end
						PH_LO_HI: begin
							acc_q[63:32] <= acc_q[63:32] + mul_p[31:0];
							phase_q      <= PH_MWC;
						end
						default: begin
							lcg_q <= lcg_new;
							xs_q  <= (seed_q && seed_phase_q == 2'd0) ? lcg_new : xs_new;
							mwc_q <= (seed_q && seed_phase_q == 2'd1) ? xs_new : mwc_new;
							if (seed_q) begin
								seed_phase_q <= seed_phase_q + 2'd1;
							end
							phase_q <= PH_LO_LO;
							state_q <= S_NEXT;
						end
					endcase
				end
				S_DELIVER: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						draw_q      <= 1'b0;
						state_q     <= S_IDLE;
						if (!wide) begin
							buf_q  <= buf_q >> w_amt;
							bits_q <= bits_q - w_amt;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DELIVER && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= wide ? gen : (buf_q & mask);
		end
	end

endmodule

`default_nettype wire
